>>> design/b128_pkg.sv
// shared types and constants for the base128 printable codec
`timescale 1ns / 1ps

package b128_pkg;

    localparam logic [7:0] SYM_OFFSET   = 8'd33;
    localparam logic [7:0] PAYLOAD_MASK = 8'h7F;
    localparam logic [2:0] GROUP_BITS   = 3'd7;

    // entries in the queue between front and back
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic
    {
        DIR_ENCODE = 1'b0,
        DIR_DECODE = 1'b1
    } direction_t;

    typedef enum logic
    {
        PH_FIRST  = 1'b0,
        PH_SECOND = 1'b1
    } phase_t;

    // one or two output words caused by one input word
    typedef struct packed
    {
        logic [7:0] first_data;
        logic       first_has;
        logic       first_last;
        logic       two;
        logic [7:0] second_data;
        logic       second_last;
    } result_pair_t;

    typedef struct packed
    {
        logic full;
        logic empty;
    } queue_status_t;

endpackage

>>> design/b128_front.sv
// front end: accepts input words, tracks cursor and carry, builds result pairs
`timescale 1ns / 1ps

module b128_front
    import b128_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_we,
    input  logic          cfg_wdata,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    input  logic [7:0]    s_axis_tdata,
    input  logic          s_axis_tlast,
    input  queue_status_t q_status,
    output logic          push,
    output result_pair_t  push_data
);

    direction_t direction_reg;
    logic [2:0] cursor_reg;
    logic [2:0] cursor_next;
    logic [7:0] held_reg;
    logic [7:0] held_next;
    logic       accept;

    logic [2:0] enc_bit;
    logic [2:0] enc_bit_inc;
    logic [7:0] enc_word;
    logic [7:0] enc_carry;
    logic [7:0] enc_sym;
    logic [7:0] enc_carry_sym;
    logic [7:0] dec_cur;
    logic [2:0] dec_shift;
    logic [7:0] dec_byte;

    function automatic logic [7:0] to_symbol(input logic [7:0] bits);
        return (bits & PAYLOAD_MASK) + SYM_OFFSET;
    endfunction

    always_comb
    begin
        s_axis_tready = !q_status.full;
        accept        = s_axis_tvalid && !q_status.full;

        // encode path
        enc_bit       = (cursor_reg >= GROUP_BITS) ? 3'd0 : cursor_reg;
        enc_bit_inc   = enc_bit + 3'd1;
        enc_word      = held_reg | (s_axis_tdata << enc_bit);
        enc_carry     = s_axis_tdata >> (GROUP_BITS - enc_bit);
        enc_sym       = to_symbol(enc_word);
        enc_carry_sym = to_symbol(enc_carry);

        // decode path, offset removal wraps
        dec_cur   = s_axis_tdata - SYM_OFFSET;
        dec_shift = cursor_reg - 3'd1;
        dec_byte  = (held_reg >> dec_shift) | (dec_cur << (GROUP_BITS - dec_shift));

        push_data = '0;
        push      = 1'b0;

        if (direction_reg == DIR_ENCODE)
        begin
            push                 = accept;
            push_data.first_data = enc_sym;
            push_data.first_has  = 1'b1;
            push_data.first_last = 1'b0;
            push_data.second_data = enc_carry_sym;
            if (enc_bit_inc == GROUP_BITS)
            begin
                push_data.two         = 1'b1;
                push_data.second_last = s_axis_tlast;
                cursor_next           = 3'd0;
                held_next             = 8'd0;
            end
            else
            begin
                push_data.two         = s_axis_tlast;
                push_data.second_last = 1'b1;
                cursor_next           = enc_bit_inc;
                held_next             = enc_carry;
            end
        end
        else
        begin
            held_next = dec_cur;
            if (cursor_reg == 3'd0)
            begin
                // opening symbol of a group gives a word only as an end marker
                push                 = accept && s_axis_tlast;
                push_data.first_data = 8'd0;
                push_data.first_has  = 1'b0;
                push_data.first_last = 1'b1;
                cursor_next          = 3'd1;
            end
            else
            begin
                push                 = accept;
                push_data.first_data = dec_byte;
                push_data.first_has  = 1'b1;
                push_data.first_last = s_axis_tlast;
                cursor_next          = (cursor_reg == GROUP_BITS) ? 3'd0 : cursor_reg + 3'd1;
            end
        end

        if (s_axis_tlast)
        begin
            cursor_next = 3'd0;
            held_next   = 8'd0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            direction_reg <= DIR_ENCODE;
            cursor_reg    <= 3'd0;
            held_reg      <= 8'd0;
        end
        else if (cfg_we)
        begin
            direction_reg <= direction_t'(cfg_wdata);
            cursor_reg    <= 3'd0;
            held_reg      <= 8'd0;
        end
        else if (accept)
        begin
            cursor_reg <= cursor_next;
            held_reg   <= held_next;
        end
    end

endmodule

>>> design/b128_queue.sv
// short queue of result pairs between front and back
`timescale 1ns / 1ps

module b128_queue
    import b128_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  result_pair_t  push_data,
    input  logic          pop,
    output result_pair_t  head,
    output queue_status_t status
);

    result_pair_t           entry_reg [QUEUE_DEPTH];
    logic [QUEUE_PTR_W-1:0] wr_ptr_reg;
    logic [QUEUE_PTR_W-1:0] wr_ptr_next;
    logic [QUEUE_PTR_W-1:0] rd_ptr_reg;
    logic [QUEUE_PTR_W-1:0] rd_ptr_next;
    logic [QUEUE_CNT_W-1:0] count_reg;
    logic [QUEUE_CNT_W-1:0] count_next;
    logic                   do_push;
    logic                   do_pop;

    localparam logic [QUEUE_PTR_W-1:0] LAST_PTR = QUEUE_PTR_W'(QUEUE_DEPTH - 1);
    localparam logic [QUEUE_PTR_W-1:0] PTR_ONE  = QUEUE_PTR_W'(1);
    localparam logic [QUEUE_CNT_W-1:0] FULL_CNT = QUEUE_CNT_W'(QUEUE_DEPTH);
    localparam logic [QUEUE_CNT_W-1:0] CNT_ONE  = QUEUE_CNT_W'(1);

    always_comb
    begin
        status.full  = (count_reg == FULL_CNT);
        status.empty = (count_reg == '0);
        do_push      = push && !status.full;
        do_pop       = pop && !status.empty;
        head         = entry_reg[rd_ptr_reg];

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_ONE;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_ONE;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_ONE;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_ONE;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

>>> design/b128_back.sv
// back end: sends the one or two output words of each queued pair
`timescale 1ns / 1ps

module b128_back
    import b128_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  result_pair_t  head,
    input  queue_status_t q_status,
    output logic          pop,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    output logic [7:0]    m_axis_tdata,
    output logic          m_axis_tlast,
    output logic [0:0]    m_axis_tuser
);

    phase_t phase_reg;
    phase_t phase_next;
    logic   fire;

    always_comb
    begin
        m_axis_tvalid = !q_status.empty;
        fire          = m_axis_tvalid && m_axis_tready;
        pop           = 1'b0;
        phase_next    = phase_reg;

        case (phase_reg)
            PH_FIRST:
            begin
                m_axis_tdata    = head.first_data;
                m_axis_tuser[0] = head.first_has;
                m_axis_tlast    = head.first_last;
                if (fire)
                begin
                    if (head.two)
                    begin
                        phase_next = PH_SECOND;
                    end
                    else
                    begin
                        pop = 1'b1;
                    end
                end
            end
            PH_SECOND:
            begin
                m_axis_tdata    = head.second_data;
                m_axis_tuser[0] = 1'b1;
                m_axis_tlast    = head.second_last;
                if (fire)
                begin
                    pop        = 1'b1;
                    phase_next = PH_FIRST;
                end
            end
            default:
            begin
                m_axis_tdata    = head.first_data;
                m_axis_tuser[0] = head.first_has;
                m_axis_tlast    = head.first_last;
                phase_next      = PH_FIRST;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_FIRST;
        end
        else
        begin
            phase_reg <= phase_next;
        end
    end

endmodule

>>> design/base128_printable_codec.sv
// top level of the base128 printable codec
//
//  channel   direction  handshake                      contents
//  s_axis    in         s_axis_tvalid / s_axis_tready  tdata byte or symbol, tlast end
//  m_axis    out        m_axis_tvalid / m_axis_tready  tdata symbol or byte, tuser has_data,
//                                                      tlast end
//  cfg       in         cfg_we                         cfg_wdata direction
//
//  one input word per cycle enters the front while the two-entry queue has room
//  the back sends one output word per cycle while m_axis_tready is high, and pops a
//  word with two results after both; encode gives 8 symbols per full group of 7 bytes, decode one
//  symbol per cycle when not stalled; reset clears direction, cursor, carry and queue
//  results are registered in the queue; an output stall fills it, then drops s_axis_tready
`timescale 1ns / 1ps

module base128_printable_codec
    import b128_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // data_in
    input  logic       s_axis_tlast,
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,   // data_out
    output logic [0:0] m_axis_tuser,   // has_data
    output logic       m_axis_tlast
);

    queue_status_t q_status;
    result_pair_t  push_data;
    result_pair_t  head;
    logic          push;
    logic          pop;

    b128_front u_front
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .q_status      (q_status),
        .push          (push),
        .push_data     (push_data)
    );

    b128_queue u_queue
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .pop       (pop),
        .head      (head),
        .status    (q_status)
    );

    b128_back u_back
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (head),
        .q_status      (q_status),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

    // an end marker without data always closes the stream
    a_marker_is_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser[0] |-> m_axis_tlast)
        else $error("end marker without tlast");

    a_queue_status: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_status.full && q_status.empty))
        else $error("queue full and empty at once");

    // a word accepted while the queue was full would be dropped by the queue
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_status.full |-> !s_axis_tready)
        else $error("input ready while queue full");

    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push && s_axis_tready |=> m_axis_tvalid)
        else $error("queued result not presented");

endmodule

>>> sim/base128_printable_codec_tb.sv
// testbench for the base128 printable codec: directed and random streams checked word by word
`timescale 1ns / 1ps

typedef struct packed
{
    logic [7:0] data;
    logic       has;
    logic       last;
} codec_word_t;

class codec_scoreboard;

    localparam logic [7:0] SYMBOL_BIAS = 8'd33;
    localparam logic [2:0] BITS_PER_SYMBOL = 3'd7;

    b128_pkg::direction_t dir;
    logic [2:0]           cursor;
    logic [7:0]           held;
    codec_word_t          expected_q[$];
    int                   mismatches;
    int                   words_in;
    int                   words_out;

    function new();
        dir        = b128_pkg::DIR_ENCODE;
        cursor     = 3'd0;
        held       = 8'd0;
        mismatches = 0;
        words_in   = 0;
        words_out  = 0;
    endfunction

    function int pending();
        return expected_q.size();
    endfunction

    function void set_direction(b128_pkg::direction_t d);
        dir    = d;
        cursor = 3'd0;
        held   = 8'd0;
    endfunction

    function void push_word(logic [7:0] d, logic has, logic l);
        codec_word_t w;
        w.data = d;
        w.has  = has;
        w.last = l;
        expected_q.insert(expected_q.size(), w);
    endfunction

    function logic [7:0] printable(logic [7:0] bits);
        return {1'b0, bits[6:0]} + SYMBOL_BIAS;
    endfunction

    function void fail_msg(string msg);
        mismatches++;
        if (mismatches <= 10)
            $display("mismatch: %s", msg);
    endfunction

    // work out the output words one accepted input word causes
    function void note_input(logic [7:0] d, logic l);
        logic [2:0]  bitpos;
        logic [2:0]  shift;
        logic [15:0] merged;
        logic [7:0]  carry;
        logic [7:0]  sym;
        logic [7:0]  cur;
        words_in++;
        if (dir == b128_pkg::DIR_ENCODE)
        begin
            bitpos = (cursor >= BITS_PER_SYMBOL) ? 3'd0 : cursor;
            merged = {8'h00, held} | ({8'h00, d} << bitpos);
            sym    = printable(merged[7:0]);
            carry  = d >> (BITS_PER_SYMBOL - bitpos);
            bitpos = bitpos + 3'd1;
            push_word(sym, 1'b1, 1'b0);
            if (bitpos == BITS_PER_SYMBOL)
            begin
                push_word(printable(carry), 1'b1, l);
                carry  = 8'd0;
                bitpos = 3'd0;
            end
            else if (l)
                push_word(printable(carry), 1'b1, 1'b1);
            cursor = bitpos;
            held   = carry;
        end
        else
        begin
            // wraps for symbols below the bias, all eight bits kept
            cur = d - SYMBOL_BIAS;
            if (cursor == 3'd0)
            begin
                if (l)
                    push_word(8'd0, 1'b0, 1'b1);
                cursor = 3'd1;
            end
            else
            begin
                shift  = cursor - 3'd1;
                merged = ({8'h00, held} >> shift) | ({8'h00, cur} << (BITS_PER_SYMBOL - shift));
                push_word(merged[7:0], 1'b1, l);
                cursor = (cursor == BITS_PER_SYMBOL) ? 3'd0 : cursor + 3'd1;
            end
            held = cur;
        end
        if (l)
        begin
            cursor = 3'd0;
            held   = 8'd0;
        end
    endfunction

    function void check_output(logic [7:0] d, logic has, logic l);
        codec_word_t w;
        words_out++;
        if (expected_q.size() == 0)
        begin
            fail_msg($sformatf("unexpected word data=%02h has=%0b last=%0b", d, has, l));
            return;
        end
        w = expected_q.pop_front();
        if (w.data !== d || w.has !== has || w.last !== l)
            fail_msg($sformatf("expected data=%02h has=%0b last=%0b, got data=%02h has=%0b last=%0b",
                               w.data, w.has, w.last, d, has, l));
    endfunction

    function void flag_leftovers();
        while (expected_q.size() != 0)
        begin
            codec_word_t w;
            w = expected_q.pop_front();
            fail_msg($sformatf("missing word data=%02h has=%0b last=%0b", w.data, w.has, w.last));
        end
    endfunction

endclass

module base128_printable_codec_tb;

    import b128_pkg::*;

    localparam int STALL_LIMIT = 5000;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       s_axis_tvalid;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata;    // data_in
    logic       s_axis_tlast;
    logic       m_axis_tvalid;
    logic       m_axis_tready;
    logic [7:0] m_axis_tdata;    // data_out
    logic [0:0] m_axis_tuser;    // has_data
    logic       m_axis_tlast;

    codec_scoreboard sb;
    logic            no_idle;
    int              stall_cycles;
    int              dir_writes;

    base128_printable_codec uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #2 clk = ~clk;

    // output side backpressure
    always @(negedge clk)
    begin
        if (no_idle)
            m_axis_tready <= 1'b1;
        else
            m_axis_tready <= ($urandom_range(99) >= 35);
    end

    always @(posedge clk)
    begin
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_output(m_axis_tdata, m_axis_tuser[0], m_axis_tlast);
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= STALL_LIMIT)
        begin
            $display("timeout: no word moved for %0d cycles", STALL_LIMIT);
            $display("tb: failure");
            $finish;
        end
    end

    // entered and left just after a falling edge with no pending drive on tvalid
    task automatic send_word(input logic [7:0] d, input logic l);
        while (!no_idle && $urandom_range(99) < 35)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= 8'($urandom_range(255));
            @(negedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= d;
        s_axis_tlast  <= l;
        do
            @(posedge clk);
        while (!s_axis_tready);
        sb.note_input(d, l);
        @(negedge clk);
    endtask

    task automatic drain_outputs();
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        // a decode word that opens a group gives nothing, so let the pipe settle
        repeat (4) @(negedge clk);
    endtask

    task automatic write_direction(input direction_t d);
        drain_outputs();
        cfg_we    <= 1'b1;
        cfg_wdata <= d;
        @(negedge clk);
        cfg_we <= 1'b0;
        sb.set_direction(d);
        dir_writes++;
    endtask

    task automatic run_random(input direction_t d, input int count);
        int         sent;
        int         len;
        int         pick;
        logic       cut;
        logic [7:0] val;
        write_direction(d);
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (d == DIR_DECODE && pick < 60)
                len = 8 * $urandom_range(1, 3) + $urandom_range(0, 1);
            else if (pick < 80)
                len = $urandom_range(1, 16);
            else
                len = $urandom_range(17, 40);
            // some streams run into the next one with no end marker
            cut = ($urandom_range(99) < 10);
            for (int i = 0; i < len; i++)
            begin
                if (d == DIR_DECODE && $urandom_range(99) < 85)
                    val = 8'($urandom_range(33, 160));
                else
                    val = 8'($urandom_range(255));
                send_word(val, (i == len - 1) && !cut);
            end
            sent += len;
            if ($urandom_range(99) < 5)
                drain_outputs();
        end
    endtask

    initial
    begin
        sb            = new();
        clk           = 1'b0;
        rst_n         = 1'b0;
        cfg_we        = 1'b0;
        cfg_wdata     = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = 8'd0;
        s_axis_tlast  = 1'b0;
        m_axis_tready = 1'b0;
        no_idle       = 1'b0;
        stall_cycles  = 0;
        dir_writes    = 0;

        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // encode: field extremes, a full group of seven, flush of a partial carry
        write_direction(DIR_ENCODE);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h55, 1'b0);
        send_word(8'hAA, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hFF, 1'b1);
        // end marker on the seventh byte goes on the carry symbol
        send_word(8'h12, 1'b0);
        send_word(8'h34, 1'b0);
        send_word(8'h56, 1'b0);
        send_word(8'h78, 1'b0);
        send_word(8'h9A, 1'b0);
        send_word(8'hBC, 1'b0);
        send_word(8'hDE, 1'b1);

        // decode: lone end symbol, symbols below the bias, a full group
        write_direction(DIR_DECODE);
        send_word(8'h00, 1'b1);
        send_word(8'h20, 1'b0);
        send_word(8'h00, 1'b0);
        send_word(8'hFF, 1'b0);
        send_word(8'h21, 1'b0);
        send_word(8'h7F, 1'b0);
        send_word(8'hA0, 1'b0);
        send_word(8'h80, 1'b0);
        send_word(8'h5E, 1'b0);
        send_word(8'h41, 1'b1);

        run_random(DIR_DECODE, 130);
        run_random(DIR_ENCODE, 130);
        no_idle = 1'b1;
        run_random(DIR_DECODE, 130);
        no_idle = 1'b0;
        run_random(DIR_DECODE, 130);
        run_random(DIR_ENCODE, 130);
        run_random(DIR_DECODE, 130);

        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        sb.flag_leftovers();

        $display("covered %0d input words and %0d output words across %0d direction writes",
                 sb.words_in, sb.words_out, dir_writes);
        $display("encode and decode streams with stalls on both sides, %0d mismatches",
                 sb.mismatches);
        if (sb.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
